[sv/pjac_pkg.sv]
package pjac_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int SUM_W      = 2 * DATA_WIDTH + 2;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int POSE_WORDS = 12;
	localparam int FOCAL_W    = DATA_WIDTH - 1;
	// quotient bits kept by the divider before saturation
	localparam int QUO_W      = DATA_WIDTH + 1;
	localparam int MAG_W      = QUO_W + FOCAL_W;

	localparam int FOCAL_DEFAULT = 500;
	localparam int CX_DEFAULT    = 320;
	localparam int CY_DEFAULT    = 240;

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic signed [SUM_W-1:0]      acc_t;
	typedef logic signed [PROD_W-1:0]     prod_t;

	typedef enum logic [1:0] {
		REG_FOCAL_X,
		REG_FOCAL_Y,
		REG_CENTER_X,
		REG_CENTER_Y
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_UV,
		KIND_POSE_U,
		KIND_POSE_V,
		KIND_POINT
	} kind_t;

	localparam logic MODE_POSE  = 1'b0;
	localparam logic MODE_POINT = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [3:0] pose_slot;
		word_t      pose_word;
		word_t      point_x;
		word_t      point_y;
		word_t      point_z;
	} in_item_t;

	typedef struct packed {
		logic [1:0] row_kind;
		word_t      value0;
		word_t      value1;
		word_t      value2;
		word_t      value3;
		word_t      value4;
		word_t      value5;
		logic       depth_error;
		logic       last;
	} res_item_t;

	typedef struct packed {
		logic [FOCAL_W-1:0] fx;
		logic [FOCAL_W-1:0] fy;
		word_t              cx;
		word_t              cy;
	} cam_cfg_t;

	// one queued point with the pose it saw on arrival
	typedef struct packed {
		word_t [2:0] p;
		word_t [8:0] r;
		word_t [2:0] t;
	} job_t;

	localparam acc_t SAT_HI = {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam acc_t SAT_LO = ~SAT_HI;

	function automatic word_t sat_w(input acc_t v);
		if (v > SAT_HI) return SAT_HI[DATA_WIDTH-1:0];
		if (v < SAT_LO) return SAT_LO[DATA_WIDTH-1:0];
		return v[DATA_WIDTH-1:0];
	endfunction

	function automatic acc_t ext_w(input word_t w);
		return {{(SUM_W-DATA_WIDTH){w[DATA_WIDTH-1]}}, w};
	endfunction

	// product scaled back, rounding toward minus infinity
	function automatic acc_t floor_q(input prod_t x);
		prod_t s;
		s = x >>> FRAC_BITS;
		return {{(SUM_W-PROD_W){s[PROD_W-1]}}, s};
	endfunction

	// same for the negated product
	function automatic acc_t floor_nq(input prod_t x);
		logic signed [PROD_W:0] n;
		n = -{x[PROD_W-1], x};
		n = n >>> FRAC_BITS;
		return {{(SUM_W-PROD_W-1){n[PROD_W]}}, n};
	endfunction

endpackage

[sv/pinhole_reprojection_jacobian_top.sv]
// channel   direction  handshake          payload
// input     in         push / full        in_data  (in_item_t)
// result    out        empty / pop        out_data (res_item_t)
// config    in         cfg_wen            cfg_idx, cfg_wdata
//
// a pose word takes effect the cycle after its transfer; a point yields four
// results, one per cycle while pop is held high.
// a point passes through two 34-stage depth dividers in series.
// the back pipeline advances as one whole, held only while the result serializer waits.
// reset restores the default camera and the identity pose at once.
module pinhole_reprojection_jacobian_top
	import pjac_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  in_item_t        in_data,
	output logic            empty,
	input  logic            pop,
	output res_item_t       out_data,
	input  logic            cfg_wen,
	input  logic [1:0]      cfg_idx,
	input  logic [DATA_WIDTH-1:0] cfg_wdata
);

	cam_cfg_t cfg_q;
	logic     job_valid, job_pop;
	job_t     job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fx <= FOCAL_W'(FOCAL_DEFAULT) << FRAC_BITS;
			cfg_q.fy <= FOCAL_W'(FOCAL_DEFAULT) << FRAC_BITS;
			cfg_q.cx <= word_t'(CX_DEFAULT) <<< FRAC_BITS;
			cfg_q.cy <= word_t'(CY_DEFAULT) <<< FRAC_BITS;
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_FOCAL_X:  cfg_q.fx <= cfg_wdata[FOCAL_W-1:0];
				REG_FOCAL_Y:  cfg_q.fy <= cfg_wdata[FOCAL_W-1:0];
				REG_CENTER_X: cfg_q.cx <= cfg_wdata;
				REG_CENTER_Y: cfg_q.cy <= cfg_wdata;
			endcase
		end
	end

	pjac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_data   (in_data),
		.job_pop   (job_pop),
		.job_valid (job_valid),
		.job       (job)
	);

	pjac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.out_data  (out_data)
	);

endmodule

[sv/pjac_front.sv]
module pjac_front
	import pjac_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t in_data,
	input  logic     job_pop,
	output logic     job_valid,
	output job_t     job
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam word_t ONE_Q = word_t'(1) <<< FRAC_BITS;

	word_t              pose_q [POSE_WORDS];
	job_t               job_q  [QDEPTH];
	logic [PTR_W-1:0]   wp_q, rp_q;
	logic [PTR_W:0]     cnt_q;
	logic               take, enq, deq;
	job_t               new_job;

	assign full = (cnt_q == (PTR_W+1)'(QDEPTH));
	assign take = push && !full;
	assign enq  = take && (in_data.mode == MODE_POINT);
	assign deq  = job_pop && job_valid;

	assign job_valid = (cnt_q != '0);
	assign job       = job_q[rp_q];

	always_comb begin
		new_job.p[0] = in_data.point_x;
		new_job.p[1] = in_data.point_y;
		new_job.p[2] = in_data.point_z;
		for (int i = 0; i < 9; i++) new_job.r[i] = pose_q[i];
		for (int i = 0; i < 3; i++) new_job.t[i] = pose_q[9+i];
	end

	// pose store: identity rotation, zero translation after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POSE_WORDS; i++) begin
				pose_q[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q : '0;
			end
		end else if (take && in_data.mode == MODE_POSE
				&& in_data.pose_slot < 4'(POSE_WORDS)) begin
			pose_q[in_data.pose_slot] <= in_data.pose_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) wp_q <= wp_q + PTR_W'(1);
			if (deq) rp_q <= rp_q + PTR_W'(1);
			if (enq && !deq) cnt_q <= cnt_q + (PTR_W+1)'(1);
			else if (deq && !enq) cnt_q <= cnt_q - (PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (enq) job_q[wp_q] <= new_job;
	end

endmodule

[sv/pjac_div.sv]
module pjac_div
	import pjac_pkg::*;
#(
	parameter int LANES  = 2,
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [LANES-1:0]              in_neg,
	input  logic [LANES-1:0][MAG_W-1:0]   in_mag,
	input  logic [FOCAL_W-1:0]            in_den,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_valid,
	output word_t [LANES-1:0]             out_quo,
	output logic [SIDE_W-1:0]             out_side
);

	localparam int NB = QUO_W;
	localparam int RW = FOCAL_W;

	logic                           v_q    [0:NB];
	logic [RW-1:0]                  den_q  [0:NB];
	logic [LANES-1:0]               neg_q  [0:NB];
	logic [LANES-1:0]               ovf_q  [0:NB];
	logic [LANES-1:0][MAG_W-1:0]    mag_q  [0:NB];
	logic [LANES-1:0][RW-1:0]       rem_q  [0:NB];
	logic [LANES-1:0][NB-1:0]       quo_q  [0:NB];
	logic [SIDE_W-1:0]              side_q [0:NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	// a quotient of 2^NB or more saturates whatever the low bits say
	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0]  <= in_den;
			neg_q[0]  <= in_neg;
			mag_q[0]  <= in_mag;
			side_q[0] <= in_side;
			for (int l = 0; l < LANES; l++) begin
				ovf_q[0][l] <= (in_mag[l][MAG_W-1:NB] >= in_den);
				rem_q[0][l] <= (in_mag[l][MAG_W-1:NB] >= in_den) ? '0 : in_mag[l][MAG_W-1:NB];
				quo_q[0][l] <= '0;
			end
		end
	end

	for (genvar k = 0; k < NB; k++) begin : g_stage
		logic [LANES-1:0][RW-1:0] nrem;
		logic [LANES-1:0][NB-1:0] nquo;

		always_comb begin
			logic [RW:0] t;
			for (int l = 0; l < LANES; l++) begin
				t = {rem_q[k][l], mag_q[k][l][NB-1-k]};
				if (t >= {1'b0, den_q[k]}) begin
					nrem[l] = RW'(t - {1'b0, den_q[k]});
					nquo[l] = quo_q[k][l] | (NB'(1) << (NB-1-k));
				end else begin
					nrem[l] = t[RW-1:0];
					nquo[l] = quo_q[k][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k+1]  <= den_q[k];
				neg_q[k+1]  <= neg_q[k];
				ovf_q[k+1]  <= ovf_q[k];
				mag_q[k+1]  <= mag_q[k];
				side_q[k+1] <= side_q[k];
				rem_q[k+1]  <= nrem;
				quo_q[k+1]  <= nquo;
			end
		end
	end

	assign out_valid = v_q[NB];
	assign out_side  = side_q[NB];

	always_comb begin
		logic [NB-1:0] q;
		for (int l = 0; l < LANES; l++) begin
			q = quo_q[NB][l];
			if (neg_q[NB][l]) begin
				if (ovf_q[NB][l] || q[NB-1] || (q[NB-2] && |q[NB-3:0]))
					out_quo[l] = SAT_LO[DATA_WIDTH-1:0];
				else
					out_quo[l] = -$signed(q[DATA_WIDTH-1:0]);
			end else begin
				if (ovf_q[NB][l] || q[NB-1] || q[NB-2])
					out_quo[l] = SAT_HI[DATA_WIDTH-1:0];
				else
					out_quo[l] = $signed(q[DATA_WIDTH-1:0]);
			end
		end
	end

endmodule

[sv/pjac_back.sv]
module pjac_back
	import pjac_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cam_cfg_t  cfg,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_pop,
	output logic      empty,
	input  logic      pop,
	output res_item_t out_data
);

	typedef struct packed {
		logic               err;
		word_t [8:0]        r;
		word_t [8:0]        m;
		logic [FOCAL_W-1:0] den;
	} side1_t;

	typedef struct packed {
		logic        err;
		word_t [8:0] r;
		word_t [8:0] m;
		word_t       a;
		word_t       c;
		word_t       u;
		word_t       v;
	} side2_t;

	logic adv, ser_take;

	// stage 1: all rotation by point products
	logic        v_s1;
	prod_t       pr_s1 [3][3][3];
	word_t [2:0] t_s1;
	word_t [8:0] r_s1;

	// stage 2: camera point and -R*skew(P)
	logic        v_s2, err_s2;
	word_t [2:0] pc_s2;
	word_t [8:0] m_s2;
	word_t [8:0] r_s2;

	// stage 3: numerators of the projection
	logic        v_s3, err_s3;
	prod_t       nx_s3, ny_s3;
	word_t       z_s3;
	word_t [8:0] m_s3;
	word_t [8:0] r_s3;

	// stage 4: jacobian products, stage 5: finished rows
	logic        v_s4, err_s4;
	prod_t       pp_s4 [8][3];
	word_t       a_s4, b_s4, c_s4, d_s4, u_s4, v4_s4;
	logic        v_s5, err_s5;
	word_t [3:0][5:0] rows_s5;

	logic             ser_v_q, err_q;
	kind_t            kind_q;
	word_t [3:0][5:0] rows_q;

	assign ser_take = !ser_v_q || (kind_q == KIND_POINT && pop);
	assign adv      = !v_s5 || ser_take;
	assign job_pop  = adv && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= d2_valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					for (int l = 0; l < 3; l++)
						pr_s1[i][k][l] <= $signed(job.r[i*3+k]) * $signed(job.p[l]);
			t_s1 <= job.t;
			r_s1 <= job.r;
		end
	end

	word_t [2:0] pc_n;
	word_t [8:0] m_n;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pc_n[i] = sat_w(floor_q(pr_s1[i][0][0]) + floor_q(pr_s1[i][1][1])
				+ floor_q(pr_s1[i][2][2]) + ext_w(t_s1[i]));
			m_n[i*3+0] = sat_w(-(floor_q(pr_s1[i][1][2]) + floor_nq(pr_s1[i][2][1])));
			m_n[i*3+1] = sat_w(-(floor_nq(pr_s1[i][0][2]) + floor_q(pr_s1[i][2][0])));
			m_n[i*3+2] = sat_w(-(floor_q(pr_s1[i][0][1]) + floor_nq(pr_s1[i][1][0])));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s2  <= pc_n;
			m_s2   <= m_n;
			r_s2   <= r_s1;
			err_s2 <= pc_n[2][DATA_WIDTH-1] || (pc_n[2] == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3  <= $signed({1'b0, cfg.fx}) * pc_s2[0];
			ny_s3  <= $signed({1'b0, cfg.fy}) * pc_s2[1];
			z_s3   <= pc_s2[2];
			err_s3 <= err_s2;
			m_s3   <= m_s2;
			r_s3   <= r_s2;
		end
	end

	// first divide: fx*X, fy*Y, fx, fy by the depth
	logic [3:0]             d1_neg;
	logic [3:0][MAG_W-1:0]  d1_mag;
	logic [FOCAL_W-1:0]     d1_den;
	side1_t                 d1_side_in, d1_side;
	logic                   d1_valid;
	word_t [3:0]            d1_quo;

	always_comb begin
		d1_neg[0] = nx_s3[PROD_W-1];
		d1_neg[1] = ny_s3[PROD_W-1];
		d1_neg[2] = 1'b0;
		d1_neg[3] = 1'b0;
		d1_mag[0] = nx_s3[PROD_W-1] ? (~nx_s3 + PROD_W'(1)) : nx_s3;
		d1_mag[1] = ny_s3[PROD_W-1] ? (~ny_s3 + PROD_W'(1)) : ny_s3;
		d1_mag[2] = {{(MAG_W-FOCAL_W-FRAC_BITS){1'b0}}, cfg.fx, {FRAC_BITS{1'b0}}};
		d1_mag[3] = {{(MAG_W-FOCAL_W-FRAC_BITS){1'b0}}, cfg.fy, {FRAC_BITS{1'b0}}};
		// bad depth: keep the divider busy on a harmless divisor
		d1_den = err_s3 ? FOCAL_W'(1) : z_s3[FOCAL_W-1:0];
		d1_side_in.err = err_s3;
		d1_side_in.r   = r_s3;
		d1_side_in.m   = m_s3;
		d1_side_in.den = d1_den;
	end

	pjac_div #(
		.LANES  (4),
		.SIDE_W ($bits(side1_t))
	) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.in_neg    (d1_neg),
		.in_mag    (d1_mag),
		.in_den    (d1_den),
		.in_side   (d1_side_in),
		.out_valid (d1_valid),
		.out_quo   (d1_quo),
		.out_side  (d1_side)
	);

	// second divide: -(pu)/Z and -(pv)/Z
	logic [1:0]             d2_neg;
	logic [1:0][MAG_W-1:0]  d2_mag;
	logic [DATA_WIDTH-1:0]  abs_u, abs_v;
	side2_t                 d2_side_in, d2_side;
	logic                   d2_valid;
	word_t [1:0]            d2_quo;

	always_comb begin
		abs_u = d1_quo[0][DATA_WIDTH-1] ? (~d1_quo[0] + DATA_WIDTH'(1)) : d1_quo[0];
		abs_v = d1_quo[1][DATA_WIDTH-1] ? (~d1_quo[1] + DATA_WIDTH'(1)) : d1_quo[1];
		d2_neg[0] = !d1_quo[0][DATA_WIDTH-1];
		d2_neg[1] = !d1_quo[1][DATA_WIDTH-1];
		d2_mag[0] = {{(MAG_W-DATA_WIDTH-FRAC_BITS){1'b0}}, abs_u, {FRAC_BITS{1'b0}}};
		d2_mag[1] = {{(MAG_W-DATA_WIDTH-FRAC_BITS){1'b0}}, abs_v, {FRAC_BITS{1'b0}}};
		d2_side_in.err = d1_side.err;
		d2_side_in.r   = d1_side.r;
		d2_side_in.m   = d1_side.m;
		d2_side_in.a   = d1_quo[2];
		d2_side_in.c   = d1_quo[3];
		d2_side_in.u   = sat_w(ext_w(d1_quo[0]) + ext_w(cfg.cx));
		d2_side_in.v   = sat_w(ext_w(d1_quo[1]) + ext_w(cfg.cy));
	end

	pjac_div #(
		.LANES  (2),
		.SIDE_W ($bits(side2_t))
	) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (d1_valid),
		.in_neg    (d2_neg),
		.in_mag    (d2_mag),
		.in_den    (d1_side.den),
		.in_side   (d2_side_in),
		.out_valid (d2_valid),
		.out_quo   (d2_quo),
		.out_side  (d2_side)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				pp_s4[0][j] <= $signed(d2_side.a) * $signed(d2_side.m[j]);
				pp_s4[1][j] <= $signed(d2_quo[0]) * $signed(d2_side.m[6+j]);
				pp_s4[2][j] <= $signed(d2_side.c) * $signed(d2_side.m[3+j]);
				pp_s4[3][j] <= $signed(d2_quo[1]) * $signed(d2_side.m[6+j]);
				pp_s4[4][j] <= $signed(d2_side.a) * $signed(d2_side.r[j]);
				pp_s4[5][j] <= $signed(d2_quo[0]) * $signed(d2_side.r[6+j]);
				pp_s4[6][j] <= $signed(d2_side.c) * $signed(d2_side.r[3+j]);
				pp_s4[7][j] <= $signed(d2_quo[1]) * $signed(d2_side.r[6+j]);
			end
			a_s4   <= d2_side.a;
			b_s4   <= d2_quo[0];
			c_s4   <= d2_side.c;
			d_s4   <= d2_quo[1];
			u_s4   <= d2_side.u;
			v4_s4  <= d2_side.v;
			err_s4 <= d2_side.err;
		end
	end

	word_t [3:0][5:0] rows_n;
	always_comb begin
		rows_n = '0;
		if (!err_s4) begin
			rows_n[0][0] = u_s4;
			rows_n[0][1] = v4_s4;
			rows_n[1][0] = a_s4;
			rows_n[1][2] = b_s4;
			rows_n[2][1] = c_s4;
			rows_n[2][2] = d_s4;
			for (int j = 0; j < 3; j++) begin
				rows_n[1][3+j] = sat_w(floor_q(pp_s4[0][j]) + floor_q(pp_s4[1][j]));
				rows_n[2][3+j] = sat_w(floor_q(pp_s4[2][j]) + floor_q(pp_s4[3][j]));
				rows_n[3][j]   = sat_w(floor_q(pp_s4[4][j]) + floor_q(pp_s4[5][j]));
				rows_n[3][3+j] = sat_w(floor_q(pp_s4[6][j]) + floor_q(pp_s4[7][j]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rows_s5 <= rows_n;
			err_s5  <= err_s4;
		end
	end

	// four results per point, one per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			kind_q  <= KIND_UV;
		end else if (ser_v_q && pop && kind_q != KIND_POINT) begin
			kind_q <= kind_t'(kind_q + 2'd1);
		end else if (ser_take) begin
			ser_v_q <= v_s5;
			kind_q  <= KIND_UV;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_take) begin
			rows_q <= rows_s5;
			err_q  <= err_s5;
		end
	end

	assign empty = !ser_v_q;

	always_comb begin
		out_data.row_kind    = kind_q;
		out_data.value0      = rows_q[kind_q][0];
		out_data.value1      = rows_q[kind_q][1];
		out_data.value2      = rows_q[kind_q][2];
		out_data.value3      = rows_q[kind_q][3];
		out_data.value4      = rows_q[kind_q][4];
		out_data.value5      = rows_q[kind_q][5];
		out_data.depth_error = err_q;
		out_data.last        = (kind_q == KIND_POINT);
	end

endmodule
